// ===== hw/rtl/bsfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared constants and types of the byte-stuffing frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] ADDR_BYTE = 8'h03;

  // line byte slots of one item, in send order
  localparam int unsigned PH_FLAG0 = 0;
  localparam int unsigned PH_ADDR  = 1;
  localparam int unsigned PH_CTRL  = 2;
  localparam int unsigned PH_BCC1  = 3;
  localparam int unsigned PH_DESC  = 4;
  localparam int unsigned PH_DATA  = 5;
  localparam int unsigned PH_CESC  = 6;
  localparam int unsigned PH_BCC2  = 7;
  localparam int unsigned PH_FLAG1 = 8;
  localparam int unsigned NUM_PH   = 9;

  typedef logic [NUM_PH-1:0] ph_mask_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] ctrl;
    logic [7:0] bcc;
    ph_mask_t   mask;
  } item_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
  endfunction

endpackage

// ===== hw/rtl/bsfb_load.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_load
// Running XOR of the payload and the slot mask of the incoming item.
// ----------------------------------------------------------------------------
module bsfb_load (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_i,
  input  logic           first_i,
  input  logic           last_i,
  input  logic [7:0]     ctrl_i,
  output bsfb_pkg::item_t item_o
);
  import bsfb_pkg::*;

  logic [7:0] chk_q, chk_d;
  logic [7:0] chk_new;

  assign chk_new = (first_i ? 8'h00 : chk_q) ^ data_i;
  assign chk_d   = last_i ? 8'h00 : chk_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= 8'h00;
    end else if (accept_i) begin
      chk_q <= chk_d;
    end
  end

  always_comb begin
    item_o.data           = data_i;
    item_o.ctrl           = ctrl_i;
    item_o.bcc            = chk_new;
    item_o.mask           = '0;
    item_o.mask[PH_FLAG0] = first_i;
    item_o.mask[PH_ADDR]  = first_i;
    item_o.mask[PH_CTRL]  = first_i;
    item_o.mask[PH_BCC1]  = first_i;
    item_o.mask[PH_DESC]  = needs_esc(data_i);
    item_o.mask[PH_DATA]  = 1'b1;
    item_o.mask[PH_CESC]  = last_i & needs_esc(chk_new);
    item_o.mask[PH_BCC2]  = last_i;
    item_o.mask[PH_FLAG1] = last_i;
  end

endmodule

// ===== hw/rtl/bsfb_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_emit
// Item register, line byte selection and output register.
// ----------------------------------------------------------------------------
module bsfb_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsfb_pkg::item_t item_i,
  input  logic            load_i,
  output logic            ready_o,
  input  logic            m_tready_i,
  output logic            m_tvalid_o,
  output logic [7:0]      m_tdata_o,
  output logic            m_tlast_o,
  output logic            m_tuser_o
);
  import bsfb_pkg::*;

  ph_mask_t   rem_q, rem_d;
  ph_mask_t   cur;
  logic [7:0] data_q, ctrl_q, bcc_q;
  logic       single, adv;
  logic [7:0] sel;
  logic       ovld_q;
  logic [7:0] obyte_q;
  logic       olast_q, oend_q;

  assign cur     = rem_q & (~rem_q + ph_mask_t'(1));
  assign single  = (rem_q != '0) && ((rem_q & (rem_q - ph_mask_t'(1))) == '0);
  assign adv     = (rem_q != '0) && (!ovld_q || m_tready_i);
  assign ready_o = (rem_q == '0) || (single && adv);

  always_comb begin
    priority if (cur[PH_FLAG0]) begin
      sel = FLAG_BYTE;
    end else if (cur[PH_ADDR]) begin
      sel = ADDR_BYTE;
    end else if (cur[PH_CTRL]) begin
      sel = ctrl_q;
    end else if (cur[PH_BCC1]) begin
      sel = ADDR_BYTE ^ ctrl_q;
    end else if (cur[PH_DESC]) begin
      sel = ESC_BYTE;
    end else if (cur[PH_DATA]) begin
      sel = needs_esc(data_q) ? esc_code(data_q) : data_q;
    end else if (cur[PH_CESC]) begin
      sel = ESC_BYTE;
    end else if (cur[PH_BCC2]) begin
      sel = needs_esc(bcc_q) ? esc_code(bcc_q) : bcc_q;
    end else begin
      sel = FLAG_BYTE;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (load_i) begin
      rem_d = item_i.mask;
    end else if (adv) begin
      rem_d = rem_q & ~cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= item_i.data;
      ctrl_q <= item_i.ctrl;
      bcc_q  <= item_i.bcc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= 1'b1;
    end else if (m_tready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      obyte_q <= sel;
      olast_q <= single;
      oend_q  <= cur[PH_FLAG1];
    end
  end

  assign m_tvalid_o = ovld_q;
  assign m_tdata_o  = obyte_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oend_q;

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == '0) || (single && adv))
    else $error("item loaded over pending line bytes");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) && ovld_q && !m_tready_i |=> $stable(rem_q))
    else $error("pending slots changed while output stalled");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && oend_q |-> olast_q)
    else $error("closing flag not marked as last of item");

  a_single_gives_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && single |=> ovld_q && olast_q)
    else $error("final slot of item not flagged last");

endmodule

// ===== hw/rtl/byte_stuffing_frame_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_frame_builder
// HDLC-like information frame builder with byte stuffing.
// ----------------------------------------------------------------------------
// Each accepted payload byte produces line bytes on the single output byte
// lane, one per cycle while m_axis_tready_i does not stall: 1 or 2 for a plain
// or escaped byte, plus 4 header bytes on the first byte of a frame and 2 to 3
// trailer bytes (BCC2 with its optional escape, closing flag) on the last, so
// an item yields 1 to 9 line bytes. The next item is taken in the cycle the
// current item's final byte moves to the output register: no gaps between items.
module byte_stuffing_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] data_byte, [15:8] control_byte
  input  logic [0:0]  s_axis_tuser_i,  // [0] first_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic [0:0]  m_axis_tuser_o,  // [0] frame_end
  output logic        m_axis_tlast_o   // run_last
);
  import bsfb_pkg::*;

  item_t item;
  logic  accept;
  logic  frame_end;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  bsfb_load u_load (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (s_axis_tdata_i[7:0]),
    .first_i  (s_axis_tuser_i[0]),
    .last_i   (s_axis_tlast_i),
    .ctrl_i   (s_axis_tdata_i[15:8]),
    .item_o   (item)
  );

  bsfb_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .load_i     (accept),
    .ready_o    (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (frame_end)
  );

  assign m_axis_tuser_o[0] = frame_end;

endmodule
